[rtl/linear_kalman_filter_step_defines.svh]
// Assertion macros used by the checker file.
`ifndef LINEAR_KALMAN_FILTER_STEP_DEFINES_SVH
`define LINEAR_KALMAN_FILTER_STEP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKFS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kalman step check failed");

// The consequent must hold in the cycle after the antecedent.
`define LKFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kalman step check failed");

`endif

[rtl/lkfs_pkg.sv]
package lkfs_pkg;

  localparam int ACC_W   = 48;
  localparam int OPW     = 32;
  localparam int B_W     = 16;
  localparam int BCNT_W  = 4;
  localparam int RAM_DEPTH = 32;
  localparam int ADDR_W  = 5;
  localparam int OP_W    = 6;
  localparam int PC_W    = 6;
  localparam int DIV_W   = 49;
  localparam int DCNT_W  = 6;

  localparam logic [PC_W-1:0] LAST_PC  = 6'd52;
  localparam logic [PC_W-1:0] INIT_END = 6'd5;

  localparam logic [2:0] REG_F  = 3'd0;
  localparam logic [2:0] REG_B  = 3'd1;
  localparam logic [2:0] REG_H  = 3'd2;
  localparam logic [2:0] REG_Q  = 3'd3;
  localparam logic [2:0] REG_R  = 3'd4;
  localparam logic [2:0] REG_P0 = 3'd5;
  localparam logic [2:0] REG_X0 = 3'd6;

  localparam logic FUNC_INIT = 1'b0;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  localparam logic [OP_W-1:0] OP_EST0 = 6'd0;
  localparam logic [OP_W-1:0] OP_EST1 = 6'd1;
  localparam logic [OP_W-1:0] OP_COV0 = 6'd2;
  localparam logic [OP_W-1:0] OP_COV1 = 6'd3;
  localparam logic [OP_W-1:0] OP_COV2 = 6'd4;
  localparam logic [OP_W-1:0] OP_COV3 = 6'd5;
  localparam logic [OP_W-1:0] OP_XP0  = 6'd6;
  localparam logic [OP_W-1:0] OP_XP1  = 6'd7;
  localparam logic [OP_W-1:0] OP_M0   = 6'd8;
  localparam logic [OP_W-1:0] OP_M1   = 6'd9;
  localparam logic [OP_W-1:0] OP_M2   = 6'd10;
  localparam logic [OP_W-1:0] OP_M3   = 6'd11;
  localparam logic [OP_W-1:0] OP_PP0  = 6'd12;
  localparam logic [OP_W-1:0] OP_PP1  = 6'd13;
  localparam logic [OP_W-1:0] OP_PP2  = 6'd14;
  localparam logic [OP_W-1:0] OP_PP3  = 6'd15;
  localparam logic [OP_W-1:0] OP_PHT0 = 6'd16;
  localparam logic [OP_W-1:0] OP_PHT1 = 6'd17;
  localparam logic [OP_W-1:0] OP_Y    = 6'd18;
  localparam logic [OP_W-1:0] OP_K0   = 6'd19;
  localparam logic [OP_W-1:0] OP_K1   = 6'd20;
  localparam logic [OP_W-1:0] OP_A0   = 6'd21;
  localparam logic [OP_W-1:0] OP_A1   = 6'd22;
  localparam logic [OP_W-1:0] OP_A2   = 6'd23;
  localparam logic [OP_W-1:0] OP_A3   = 6'd24;
  localparam logic [OP_W-1:0] OP_F0   = 6'd32;
  localparam logic [OP_W-1:0] OP_F1   = 6'd33;
  localparam logic [OP_W-1:0] OP_F2   = 6'd34;
  localparam logic [OP_W-1:0] OP_F3   = 6'd35;
  localparam logic [OP_W-1:0] OP_B0   = 6'd36;
  localparam logic [OP_W-1:0] OP_B1   = 6'd37;
  localparam logic [OP_W-1:0] OP_H0   = 6'd38;
  localparam logic [OP_W-1:0] OP_H1   = 6'd39;
  localparam logic [OP_W-1:0] OP_Q0   = 6'd40;
  localparam logic [OP_W-1:0] OP_Q1   = 6'd41;
  localparam logic [OP_W-1:0] OP_Q2   = 6'd42;
  localparam logic [OP_W-1:0] OP_Q3   = 6'd43;
  localparam logic [OP_W-1:0] OP_R    = 6'd44;
  localparam logic [OP_W-1:0] OP_U    = 6'd45;
  localparam logic [OP_W-1:0] OP_ONE  = 6'd46;

  typedef enum logic [2:0] {
    WB_RND, WB_RND_SAT, WB_RND_S, WB_ZMINUS, WB_ONEMINUS, WB_NEGRND, WB_DIV
  } wb_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_FA, ST_FB, ST_LB, ST_MUL, ST_WB, ST_DIV, ST_DWB, ST_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   a;
    logic [OP_W-1:0]   b;
    logic              first;
    logic              last;
    wb_kind_t          kind;
    logic [ADDR_W-1:0] dest;
  } uop_t;

  function automatic uop_t mk(input logic [OP_W-1:0] a, input logic [OP_W-1:0] b,
                              input logic first, input logic last,
                              input wb_kind_t kind, input logic [OP_W-1:0] dest);
    uop_t u;
    u.a = a;
    u.b = b;
    u.first = first;
    u.last = last;
    u.kind = kind;
    u.dest = dest[ADDR_W-1:0];
    return u;
  endfunction

  // Each entry is one product term; a group of terms closes with a write-back.
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(OP_B0,   OP_U,    1'b1, 1'b0, WB_RND,      OP_EST0);
      6'd1:  u = mk(OP_F0,   OP_EST0, 1'b0, 1'b0, WB_RND,      OP_EST0);
      6'd2:  u = mk(OP_F1,   OP_EST1, 1'b0, 1'b1, WB_RND_SAT,  OP_XP0);
      6'd3:  u = mk(OP_B1,   OP_U,    1'b1, 1'b0, WB_RND,      OP_EST0);
      6'd4:  u = mk(OP_F2,   OP_EST0, 1'b0, 1'b0, WB_RND,      OP_EST0);
      6'd5:  u = mk(OP_F3,   OP_EST1, 1'b0, 1'b1, WB_RND_SAT,  OP_XP1);
      6'd6:  u = mk(OP_F0,   OP_COV0, 1'b1, 1'b0, WB_RND,      OP_M0);
      6'd7:  u = mk(OP_F1,   OP_COV2, 1'b0, 1'b1, WB_RND,      OP_M0);
      6'd8:  u = mk(OP_F0,   OP_COV1, 1'b1, 1'b0, WB_RND,      OP_M1);
      6'd9:  u = mk(OP_F1,   OP_COV3, 1'b0, 1'b1, WB_RND,      OP_M1);
      6'd10: u = mk(OP_F2,   OP_COV0, 1'b1, 1'b0, WB_RND,      OP_M2);
      6'd11: u = mk(OP_F3,   OP_COV2, 1'b0, 1'b1, WB_RND,      OP_M2);
      6'd12: u = mk(OP_F2,   OP_COV1, 1'b1, 1'b0, WB_RND,      OP_M3);
      6'd13: u = mk(OP_F3,   OP_COV3, 1'b0, 1'b1, WB_RND,      OP_M3);
      6'd14: u = mk(OP_M0,   OP_F0,   1'b1, 1'b0, WB_RND,      OP_PP0);
      6'd15: u = mk(OP_M1,   OP_F1,   1'b0, 1'b0, WB_RND,      OP_PP0);
      6'd16: u = mk(OP_Q0,   OP_ONE,  1'b0, 1'b1, WB_RND_SAT,  OP_PP0);
      6'd17: u = mk(OP_M0,   OP_F2,   1'b1, 1'b0, WB_RND,      OP_PP1);
      6'd18: u = mk(OP_M1,   OP_F3,   1'b0, 1'b0, WB_RND,      OP_PP1);
      6'd19: u = mk(OP_Q1,   OP_ONE,  1'b0, 1'b1, WB_RND_SAT,  OP_PP1);
      6'd20: u = mk(OP_M2,   OP_F0,   1'b1, 1'b0, WB_RND,      OP_PP2);
      6'd21: u = mk(OP_M3,   OP_F1,   1'b0, 1'b0, WB_RND,      OP_PP2);
      6'd22: u = mk(OP_Q2,   OP_ONE,  1'b0, 1'b1, WB_RND_SAT,  OP_PP2);
      6'd23: u = mk(OP_M2,   OP_F2,   1'b1, 1'b0, WB_RND,      OP_PP3);
      6'd24: u = mk(OP_M3,   OP_F3,   1'b0, 1'b0, WB_RND,      OP_PP3);
      6'd25: u = mk(OP_Q3,   OP_ONE,  1'b0, 1'b1, WB_RND_SAT,  OP_PP3);
      6'd26: u = mk(OP_PP0,  OP_H0,   1'b1, 1'b0, WB_RND,      OP_PHT0);
      6'd27: u = mk(OP_PP1,  OP_H1,   1'b0, 1'b1, WB_RND,      OP_PHT0);
      6'd28: u = mk(OP_PP2,  OP_H0,   1'b1, 1'b0, WB_RND,      OP_PHT1);
      6'd29: u = mk(OP_PP3,  OP_H1,   1'b0, 1'b1, WB_RND,      OP_PHT1);
      6'd30: u = mk(OP_PHT0, OP_H0,   1'b1, 1'b0, WB_RND,      OP_EST0);
      6'd31: u = mk(OP_PHT1, OP_H1,   1'b0, 1'b0, WB_RND,      OP_EST0);
      6'd32: u = mk(OP_R,    OP_ONE,  1'b0, 1'b1, WB_RND_S,    OP_EST0);
      6'd33: u = mk(OP_XP0,  OP_H0,   1'b1, 1'b0, WB_RND,      OP_Y);
      6'd34: u = mk(OP_XP1,  OP_H1,   1'b0, 1'b1, WB_ZMINUS,   OP_Y);
      6'd35: u = mk(OP_PHT0, OP_ONE,  1'b1, 1'b1, WB_DIV,      OP_K0);
      6'd36: u = mk(OP_PHT1, OP_ONE,  1'b1, 1'b1, WB_DIV,      OP_K1);
      6'd37: u = mk(OP_Y,    OP_K0,   1'b1, 1'b0, WB_RND,      OP_EST0);
      6'd38: u = mk(OP_XP0,  OP_ONE,  1'b0, 1'b1, WB_RND_SAT,  OP_EST0);
      6'd39: u = mk(OP_Y,    OP_K1,   1'b1, 1'b0, WB_RND,      OP_EST1);
      6'd40: u = mk(OP_XP1,  OP_ONE,  1'b0, 1'b1, WB_RND_SAT,  OP_EST1);
      6'd41: u = mk(OP_K0,   OP_H0,   1'b1, 1'b1, WB_ONEMINUS, OP_A0);
      6'd42: u = mk(OP_K0,   OP_H1,   1'b1, 1'b1, WB_NEGRND,   OP_A1);
      6'd43: u = mk(OP_K1,   OP_H0,   1'b1, 1'b1, WB_NEGRND,   OP_A2);
      6'd44: u = mk(OP_K1,   OP_H1,   1'b1, 1'b1, WB_ONEMINUS, OP_A3);
      6'd45: u = mk(OP_A0,   OP_PP0,  1'b1, 1'b0, WB_RND,      OP_COV0);
      6'd46: u = mk(OP_A1,   OP_PP2,  1'b0, 1'b1, WB_RND_SAT,  OP_COV0);
      6'd47: u = mk(OP_A0,   OP_PP1,  1'b1, 1'b0, WB_RND,      OP_COV1);
      6'd48: u = mk(OP_A1,   OP_PP3,  1'b0, 1'b1, WB_RND_SAT,  OP_COV1);
      6'd49: u = mk(OP_A2,   OP_PP0,  1'b1, 1'b0, WB_RND,      OP_COV2);
      6'd50: u = mk(OP_A3,   OP_PP2,  1'b0, 1'b1, WB_RND_SAT,  OP_COV2);
      6'd51: u = mk(OP_A2,   OP_PP1,  1'b1, 1'b0, WB_RND,      OP_COV3);
      6'd52: u = mk(OP_A3,   OP_PP3,  1'b0, 1'b1, WB_RND_SAT,  OP_COV3);
      default: u = mk(OP_ONE, OP_ONE, 1'b1, 1'b1, WB_RND, OP_EST0);
    endcase
    return u;
  endfunction

endpackage

[rtl/lkfs_ram.sv]
module lkfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[rtl/linear_kalman_filter_step.sv]
// Two-state linear Kalman filter step in signed fixed point. A beat with
// tuser 0 loads the estimate and covariance from the initial_estimate and
// initial_covariance registers; a beat with tuser 1 predicts and corrects
// with the measurement and control input, or, before the first initialize,
// returns status 1. An update passes 53 product terms through a bit-serial
// multiplier (fetch states FA, FB and LB, then a shift over the low 16 bits
// of the second operand, one multiplier bit per cycle), and each of the two
// gain divisions runs a restoring divider at one quotient bit per cycle.
// Intermediates live in a 32-entry scratch memory. The next input beat is
// taken once the block is back in idle, even while a result waits.
module linear_kalman_filter_step #(
  parameter int STATE_DIM   = 2,
  parameter int ENTRY_WIDTH = 16,
  parameter int FRAC_BITS   = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // measurement, control_input
  input  logic [0:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // estimate_first, estimate_second
  output logic [1:0]  out_tuser,  // status, saturated
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int ACC_W = lkfs_pkg::ACC_W;
  localparam int OPW   = lkfs_pkg::OPW;
  localparam int DIV_W = lkfs_pkg::DIV_W;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2**(ENTRY_WIDTH-1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(2**(FRAC_BITS-1));
  localparam logic signed [OPW-1:0]   ONE    = OPW'(2**FRAC_BITS);
  localparam logic [DIV_W-1:0] QMAX = DIV_W'(2**(ENTRY_WIDTH-1) - 1);

  logic [63:0] f_r, q_r, p0_r;
  logic [31:0] b_r, h_r, x0_r;
  logic [14:0] r_r;

  lkfs_pkg::state_t state_r, state_nxt;
  logic [lkfs_pkg::PC_W-1:0]   pc_r;
  logic signed [ACC_W-1:0]     acc_r, a_sh_r;
  logic [lkfs_pkg::B_W-1:0]    b_sr_r;
  logic [lkfs_pkg::BCNT_W-1:0] bcnt_r;
  logic signed [OPW-1:0]       s_r;
  logic [15:0]                 z_r, u_r;
  logic [15:0]                 est0_r, est1_r;
  logic                        init_r, clip_r, status_r;
  logic [DIV_W-1:0]            dvd_r;
  logic [OPW:0]                rem_r;
  logic [OPW-1:0]              ad_r;
  logic                        neg_r;
  logic [lkfs_pkg::DCNT_W-1:0] dcnt_r;
  logic                        out_valid_r, out_status_r, out_sat_r;
  logic [15:0]                 out_e0_r, out_e1_r;

  lkfs_pkg::uop_t uop;
  logic                       in_fire, cfg_we, out_load;
  logic                       ram_we;
  logic [lkfs_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [OPW-1:0]             ram_wdata, ram_rdata;
  logic signed [OPW-1:0]      a_val, b_val, init_val;
  logic signed [ACC_W-1:0]    rnd_sum, rnd_v, sat_v, term;
  logic                       sat_clip;
  logic signed [OPW-1:0]      wb_val;
  logic                       wb_clip;
  logic [OPW:0]               trial;
  logic                       ge;
  logic [ACC_W-1:0]           abs_n;
  logic [OPW-1:0]             abs_d;
  logic signed [OPW-1:0]      div_val;
  logic                       div_clip;

  function automatic logic signed [OPW-1:0] slot(input logic [63:0] word, input int idx);
    logic [ENTRY_WIDTH-1:0] e;
    e = word[16*idx +: ENTRY_WIDTH];
    if (STATE_DIM == 1 && idx != 0) begin
      return '0;
    end
    return {{(OPW-ENTRY_WIDTH){e[ENTRY_WIDTH-1]}}, e};
  endfunction

  function automatic logic signed [OPW-1:0] cfg_op(input logic [lkfs_pkg::OP_W-1:0] code);
    logic signed [OPW-1:0] v;
    unique case (code)
      lkfs_pkg::OP_F0:  v = slot(f_r, 0);
      lkfs_pkg::OP_F1:  v = slot(f_r, 1);
      lkfs_pkg::OP_F2:  v = slot(f_r, 2);
      lkfs_pkg::OP_F3:  v = slot(f_r, 3);
      lkfs_pkg::OP_B0:  v = slot({32'd0, b_r}, 0);
      lkfs_pkg::OP_B1:  v = slot({32'd0, b_r}, 1);
      lkfs_pkg::OP_H0:  v = slot({32'd0, h_r}, 0);
      lkfs_pkg::OP_H1:  v = slot({32'd0, h_r}, 1);
      lkfs_pkg::OP_Q0:  v = slot(q_r, 0);
      lkfs_pkg::OP_Q1:  v = slot(q_r, 1);
      lkfs_pkg::OP_Q2:  v = slot(q_r, 2);
      lkfs_pkg::OP_Q3:  v = slot(q_r, 3);
      lkfs_pkg::OP_R:   v = {{(OPW-15){1'b0}}, r_r};
      lkfs_pkg::OP_U:   v = {{(OPW-16){u_r[15]}}, u_r};
      lkfs_pkg::OP_ONE: v = ONE;
      default:          v = '0;
    endcase
    return v;
  endfunction

  assign uop     = lkfs_pkg::uop_rom(pc_r);
  assign in_fire = in_tvalid && in_tready;
  assign cfg_we  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_paddr[5:3])
      lkfs_pkg::REG_F:  cfg_prdata = f_r;
      lkfs_pkg::REG_B:  cfg_prdata = {32'd0, b_r};
      lkfs_pkg::REG_H:  cfg_prdata = {32'd0, h_r};
      lkfs_pkg::REG_Q:  cfg_prdata = q_r;
      lkfs_pkg::REG_R:  cfg_prdata = {49'd0, r_r};
      lkfs_pkg::REG_P0: cfg_prdata = p0_r;
      lkfs_pkg::REG_X0: cfg_prdata = {32'd0, x0_r};
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r  <= 64'h1000_0000_0000_1000;
      b_r  <= '0;
      h_r  <= '0;
      q_r  <= '0;
      r_r  <= 15'd4096;
      p0_r <= 64'h1000_0000_0000_1000;
      x0_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_paddr[5:3])
        lkfs_pkg::REG_F:  f_r  <= cfg_pwdata;
        lkfs_pkg::REG_B:  b_r  <= cfg_pwdata[31:0];
        lkfs_pkg::REG_H:  h_r  <= cfg_pwdata[31:0];
        lkfs_pkg::REG_Q:  q_r  <= cfg_pwdata;
        lkfs_pkg::REG_R:  r_r  <= cfg_pwdata[14:0];
        lkfs_pkg::REG_P0: p0_r <= cfg_pwdata;
        lkfs_pkg::REG_X0: x0_r <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  lkfs_ram #(.WIDTH(OPW), .DEPTH(lkfs_pkg::RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign a_val = uop.a[lkfs_pkg::OP_W-1] ? cfg_op(uop.a) : ram_rdata;
  assign b_val = uop.b[lkfs_pkg::OP_W-1] ? cfg_op(uop.b) : ram_rdata;
  assign init_val = (pc_r < 6'd2) ? slot({32'd0, x0_r}, int'(pc_r))
                                  : slot(p0_r, int'(pc_r) - 2);

  assign term = (bcnt_r == lkfs_pkg::BCNT_W'(lkfs_pkg::B_W - 1)) ? -a_sh_r : a_sh_r;

  assign rnd_sum = acc_r + HALF;
  assign rnd_v   = rnd_sum >>> FRAC_BITS;

  always_comb begin
    sat_clip = 1'b0;
    sat_v    = rnd_v;
    if (rnd_v > SAT_HI) begin
      sat_clip = 1'b1;
      sat_v    = SAT_HI;
    end else if (rnd_v < SAT_LO) begin
      sat_clip = 1'b1;
      sat_v    = SAT_LO;
    end
  end

  always_comb begin
    wb_clip = 1'b0;
    unique case (uop.kind)
      lkfs_pkg::WB_RND_SAT: begin
        wb_val  = sat_v[OPW-1:0];
        wb_clip = sat_clip;
      end
      lkfs_pkg::WB_ZMINUS:   wb_val = {{(OPW-16){z_r[15]}}, z_r} - rnd_v[OPW-1:0];
      lkfs_pkg::WB_ONEMINUS: wb_val = ONE - rnd_v[OPW-1:0];
      lkfs_pkg::WB_NEGRND:   wb_val = OPW'(0) - rnd_v[OPW-1:0];
      default:               wb_val = rnd_v[OPW-1:0];
    endcase
  end

  assign abs_n = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : acc_r;
  assign abs_d = s_r[OPW-1] ? OPW'(-s_r) : s_r;
  assign trial = {rem_r[OPW-1:0], dvd_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, ad_r};

  always_comb begin
    div_clip = 1'b0;
    if (!neg_r) begin
      div_clip = dvd_r > QMAX;
      div_val  = div_clip ? SAT_HI[OPW-1:0] : dvd_r[OPW-1:0];
    end else begin
      div_clip = dvd_r > (QMAX + DIV_W'(1));
      div_val  = div_clip ? SAT_LO[OPW-1:0] : OPW'(0) - dvd_r[OPW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkfs_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == lkfs_pkg::FUNC_INIT) begin
            state_nxt = lkfs_pkg::ST_INIT;
          end else if (!init_r) begin
            state_nxt = lkfs_pkg::ST_DONE;
          end else begin
            state_nxt = lkfs_pkg::ST_FA;
          end
        end
      end
      lkfs_pkg::ST_INIT: begin
        if (pc_r == lkfs_pkg::INIT_END) begin
          state_nxt = lkfs_pkg::ST_DONE;
        end
      end
      lkfs_pkg::ST_FA: state_nxt = lkfs_pkg::ST_FB;
      lkfs_pkg::ST_FB: state_nxt = lkfs_pkg::ST_LB;
      lkfs_pkg::ST_LB: state_nxt = lkfs_pkg::ST_MUL;
      lkfs_pkg::ST_MUL: begin
        if (bcnt_r == lkfs_pkg::BCNT_W'(lkfs_pkg::B_W - 1)) begin
          state_nxt = uop.last ? lkfs_pkg::ST_WB : lkfs_pkg::ST_FA;
        end
      end
      lkfs_pkg::ST_WB: begin
        if (uop.kind == lkfs_pkg::WB_DIV) begin
          state_nxt = (s_r == '0) ? lkfs_pkg::ST_DWB : lkfs_pkg::ST_DIV;
        end else if (pc_r == lkfs_pkg::LAST_PC) begin
          state_nxt = lkfs_pkg::ST_DONE;
        end else begin
          state_nxt = lkfs_pkg::ST_FA;
        end
      end
      lkfs_pkg::ST_DIV: begin
        if (dcnt_r == lkfs_pkg::DCNT_W'(DIV_W - 1)) begin
          state_nxt = lkfs_pkg::ST_DWB;
        end
      end
      lkfs_pkg::ST_DWB: state_nxt = lkfs_pkg::ST_FA;
      lkfs_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = lkfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lkfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = uop.dest;
    ram_wdata = wb_val;
    ram_raddr = uop.a[lkfs_pkg::ADDR_W-1:0];
    out_load  = 1'b0;
    unique case (state_r)
      lkfs_pkg::ST_IDLE: in_tready = 1'b1;
      lkfs_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = pc_r[lkfs_pkg::ADDR_W-1:0];
        ram_wdata = init_val;
      end
      lkfs_pkg::ST_FB: ram_raddr = uop.b[lkfs_pkg::ADDR_W-1:0];
      lkfs_pkg::ST_WB: begin
        ram_we = (uop.kind != lkfs_pkg::WB_DIV) && (uop.kind != lkfs_pkg::WB_RND_S);
      end
      lkfs_pkg::ST_DWB: begin
        ram_we    = 1'b1;
        ram_wdata = div_val;
      end
      lkfs_pkg::ST_DONE: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkfs_pkg::ST_IDLE;
      pc_r        <= '0;
      init_r      <= 1'b0;
      clip_r      <= 1'b0;
      status_r    <= lkfs_pkg::STATUS_OK;
      est0_r      <= '0;
      est1_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        pc_r     <= '0;
        clip_r   <= 1'b0;
        status_r <= (in_tuser[0] != lkfs_pkg::FUNC_INIT && !init_r)
                    ? lkfs_pkg::STATUS_REFUSED : lkfs_pkg::STATUS_OK;
      end
      if (state_r == lkfs_pkg::ST_INIT) begin
        pc_r <= pc_r + 1'b1;
        if (pc_r == lkfs_pkg::INIT_END) begin
          init_r <= 1'b1;
        end
      end
      if (state_r == lkfs_pkg::ST_MUL &&
          bcnt_r == lkfs_pkg::BCNT_W'(lkfs_pkg::B_W - 1) && !uop.last) begin
        pc_r <= pc_r + 1'b1;
      end
      if (state_r == lkfs_pkg::ST_WB && uop.kind != lkfs_pkg::WB_DIV) begin
        pc_r   <= pc_r + 1'b1;
        clip_r <= clip_r | wb_clip;
      end
      if (state_r == lkfs_pkg::ST_DWB) begin
        pc_r   <= pc_r + 1'b1;
        clip_r <= clip_r | div_clip;
      end
      if (ram_we && ram_waddr == lkfs_pkg::OP_EST0[lkfs_pkg::ADDR_W-1:0]) begin
        est0_r <= ram_wdata[15:0];
      end
      if (ram_we && ram_waddr == lkfs_pkg::OP_EST1[lkfs_pkg::ADDR_W-1:0]) begin
        est1_r <= ram_wdata[15:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      z_r <= in_tdata[15:0];
      u_r <= in_tdata[31:16];
    end
    unique case (state_r)
      lkfs_pkg::ST_FB: a_sh_r <= {{(ACC_W-OPW){a_val[OPW-1]}}, a_val};
      lkfs_pkg::ST_LB: begin
        b_sr_r <= b_val[lkfs_pkg::B_W-1:0];
        bcnt_r <= '0;
        if (uop.first) begin
          acc_r <= '0;
        end
      end
      lkfs_pkg::ST_MUL: begin
        if (b_sr_r[0]) begin
          acc_r <= acc_r + term;
        end
        a_sh_r <= a_sh_r <<< 1;
        b_sr_r <= b_sr_r >> 1;
        bcnt_r <= bcnt_r + 1'b1;
      end
      lkfs_pkg::ST_WB: begin
        if (uop.kind == lkfs_pkg::WB_RND_S) begin
          s_r <= rnd_v[OPW-1:0];
        end
        neg_r  <= acc_r[ACC_W-1] ^ s_r[OPW-1];
        ad_r   <= abs_d;
        rem_r  <= '0;
        dcnt_r <= '0;
        dvd_r  <= (s_r == '0) ? '0 : ({1'b0, abs_n} + {{(DIV_W-OPW+1){1'b0}}, abs_d[OPW-1:1]});
      end
      lkfs_pkg::ST_DIV: begin
        rem_r  <= ge ? (trial - {1'b0, ad_r}) : trial;
        dvd_r  <= {dvd_r[DIV_W-2:0], ge};
        dcnt_r <= dcnt_r + 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_status_r <= status_r;
      out_sat_r    <= clip_r;
      out_e0_r     <= est0_r;
      out_e1_r     <= est1_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_e1_r, out_e0_r};
  assign out_tuser  = {out_sat_r, out_status_r};

endmodule

[rtl/lkfs_checker.sv]
`include "linear_kalman_filter_step_defines.svh"

module lkfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `LKFS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `LKFS_ASSERT_NOW(a_refused_clean, out_tvalid && out_tuser[0], !out_tuser[1])
  `LKFS_ASSERT_NEXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready)

endmodule

bind linear_kalman_filter_step lkfs_checker u_lkfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
